FILE: rtl/core/keyword_occurrence_counter_defines.svh
// Assertion macros for the keyword counter checker.
`ifndef KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH
`define KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define KOC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyword counter check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define KOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyword counter check failed");

`endif

FILE: rtl/core/kocnt_pkg.sv
package kocnt_pkg;

    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int KEY_IDX_W  = 3;
    localparam int KEY_SLOTS  = 8;
    localparam int COUNT_W    = 32;
    localparam int LEN_W      = 7;
    localparam int KLEN_W     = 5;
    localparam int KEY_TEXT_LEN = 16;

    localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_DONE = 2'd1;
    localparam logic [1:0] OP_INC  = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    typedef logic [KEY_TEXT_LEN-1:0][CHAR_W-1:0] t_kw_row;

    typedef struct packed {
        logic [1:0]           op;
        logic [KEY_IDX_W-1:0] addr;
    } t_req;

    // first character in the top byte
    localparam t_kw_row KW_TEXT [KEY_SLOTS] = '{
        {"auto",  96'd0},
        {"break", 88'd0},
        {"case",  96'd0},
        '0, '0, '0, '0, '0
    };

    localparam logic [KLEN_W-1:0] KW_LEN [KEY_SLOTS] = '{
        5'd4, 5'd5, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };

    function automatic logic [CHAR_W-1:0] kw_char(
        input logic [KEY_IDX_W-1:0] k,
        input logic [LEN_W-1:0]     p
    );
        logic [CHAR_W-1:0] ch;
        if (p >= LEN_W'(KEY_TEXT_LEN)) begin
            ch = '0;
        end else begin
            ch = KW_TEXT[k][4'(LEN_W'(KEY_TEXT_LEN - 1) - p)];
        end
        return ch;
    endfunction

endpackage

FILE: rtl/core/kocnt_in_if.sv
interface kocnt_in_if import kocnt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [CHAR_W-1:0]    char_code;
    logic [KEY_IDX_W-1:0] key_index;

    modport source (output valid, cmd, char_code, key_index, input ready);
    modport sink   (input valid, cmd, char_code, key_index, output ready);
endinterface

FILE: rtl/core/kocnt_out_if.sv
interface kocnt_out_if import kocnt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 word_done;
    logic                 keyword_hit;
    logic [KEY_IDX_W-1:0] hit_index;
    logic [COUNT_W-1:0]   count_value;

    modport source (output valid, word_done, keyword_hit, hit_index, count_value,
                    input ready);
    modport sink   (input valid, word_done, keyword_hit, hit_index, count_value,
                    output ready);
endinterface

FILE: rtl/core/keyword_occurrence_counter.sv
// Each accepted item is held in the stage-one request register, then its result in the output register.
// Throughput: one input item per cycle unless the output stalls; a count update is a read of the count RAM,
// then an increment and write-back, with same-entry forwarding between neighbors.
// Reset (synchronous, active low): clears the tokenizer state, the pipeline
// valids and the per-entry count valid bits, so all counts read zero at once.
module keyword_occurrence_counter import kocnt_pkg::*; #(
    parameter int NUM_KEYS     = 3,
    parameter int MAX_WORD_LEN = 100,
    parameter int MAX_KEY_LEN  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kocnt_in_if.sink    i_item,
    kocnt_out_if.source o_result
);
    t_req req;
    logic req_ready;
    logic fire;

    assign i_item.ready = req_ready;
    assign fire         = i_item.valid && req_ready;

    kocnt_tokenizer #(
        .NUM_KEYS     (NUM_KEYS),
        .MAX_WORD_LEN (MAX_WORD_LEN),
        .MAX_KEY_LEN  (MAX_KEY_LEN)
    ) u_tokenizer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_cmd       (i_item.cmd),
        .i_char_code (i_item.char_code),
        .i_key_index (i_item.key_index),
        .o_req       (req)
    );

    kocnt_count_stage u_count_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_item.valid),
        .i_req       (req),
        .o_req_ready (req_ready),
        .o_result    (o_result)
    );
endmodule

FILE: rtl/core/kocnt_ram.sv
module kocnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/kocnt_tokenizer.sv
module kocnt_tokenizer import kocnt_pkg::*; #(
    parameter int NUM_KEYS     = 3,
    parameter int MAX_WORD_LEN = 100,
    parameter int MAX_KEY_LEN  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [KEY_IDX_W-1:0] i_key_index,
    output t_req                 o_req
);
    localparam logic [LEN_W-1:0] WordCap = LEN_W'(MAX_WORD_LEN - 1);

    logic                 r_in_word, n_in_word;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [KEY_SLOTS-1:0] r_mask, n_mask;

    logic                 is_alpha, is_alnum;
    logic [LEN_W-1:0]     pos, app_len, cl_len;
    logic [KEY_SLOTS-1:0] base, keep, app_mask, cl_mask;
    logic [KLEN_W-1:0]    eff_len [KEY_SLOTS];
    logic                 do_append, do_close, hit;
    logic [KEY_IDX_W-1:0] hit_idx;
    t_req                 req;

    always_comb begin
        is_alpha = (i_char_code >= 8'h41 && i_char_code <= 8'h5A) ||
                   (i_char_code >= 8'h61 && i_char_code <= 8'h7A);
        is_alnum = is_alpha || (i_char_code >= 8'h30 && i_char_code <= 8'h39);

        pos  = r_in_word ? r_len : '0;
        base = r_in_word ? r_mask : '1;
        for (int k = 0; k < KEY_SLOTS; k++) begin
            eff_len[k] = (int'(KW_LEN[k]) <= MAX_KEY_LEN) ? KW_LEN[k] : '0;
            keep[k]    = (k < NUM_KEYS) && (LEN_W'(eff_len[k]) > pos) &&
                         (kw_char(KEY_IDX_W'(k), pos) == i_char_code);
        end
        app_mask = base & keep;
        app_len  = pos + 1'b1;

        do_append = 1'b0;
        do_close  = 1'b0;
        cl_mask   = r_mask;
        cl_len    = r_len;
        req.op    = OP_NONE;
        req.addr  = '0;

        unique case (i_cmd)
            CMD_CHAR: begin
                if ((r_in_word && is_alnum) || (!r_in_word && is_alpha)) begin
                    do_append = 1'b1;
                    do_close  = (app_len >= WordCap);
                    cl_mask   = app_mask;
                    cl_len    = app_len;
                end else if (r_in_word) begin
                    do_close = 1'b1;
                end
            end
            CMD_FLUSH: begin
                do_close = r_in_word;
            end
            CMD_READ: begin
                req.op   = OP_READ;
                req.addr = i_key_index;
            end
            default: begin
                req.op = OP_NONE;
            end
        endcase

        // lowest matching slot wins
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = KEY_SLOTS - 1; k >= 0; k--) begin
            if ((k < NUM_KEYS) && cl_mask[k] && (eff_len[k] != '0) &&
                (LEN_W'(eff_len[k]) == cl_len)) begin
                hit     = 1'b1;
                hit_idx = KEY_IDX_W'(k);
            end
        end

        if (do_close) begin
            req.op   = hit ? OP_INC : OP_DONE;
            req.addr = hit ? hit_idx : '0;
        end

        n_in_word = r_in_word;
        n_len     = r_len;
        n_mask    = r_mask;
        if (do_close) begin
            n_in_word = 1'b0;
            n_len     = '0;
            n_mask    = '0;
        end else if (do_append) begin
            n_in_word = 1'b1;
            n_len     = app_len;
            n_mask    = app_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_len     <= '0;
            r_mask    <= '0;
        end else if (i_fire) begin
            r_in_word <= n_in_word;
            r_len     <= n_len;
            r_mask    <= n_mask;
        end
    end

    assign o_req = req;
endmodule

FILE: rtl/core/kocnt_count_stage.sv
module kocnt_count_stage import kocnt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  t_req               i_req,
    output logic               o_req_ready,
    kocnt_out_if.source        o_result
);
    logic                 r_s1_valid;
    t_req                 r_s1_req;
    logic                 r_fwd_hit;
    logic [COUNT_W-1:0]   r_fwd_data;
    logic [KEY_SLOTS-1:0] r_vld;

    logic                 r_out_valid;
    logic                 r_out_done;
    logic                 r_out_hit;
    logic [KEY_IDX_W-1:0] r_out_idx;
    logic [COUNT_W-1:0]   r_out_count;

    logic                 adv, take, we;
    logic [KEY_IDX_W-1:0] rd_addr;
    logic [COUNT_W-1:0]   rd_data, cur, inc;

    assign adv         = r_s1_valid && (!r_out_valid || o_result.ready);
    assign o_req_ready = !r_s1_valid || adv;
    assign take        = i_req_valid && o_req_ready;
    assign rd_addr     = o_req_ready ? i_req.addr : r_s1_req.addr;
    assign we          = adv && (r_s1_req.op == OP_INC);

    kocnt_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (KEY_SLOTS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_req.addr),
        .i_wdata (inc),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // entries never written read as zero; same-edge write is forwarded
    assign cur = r_fwd_hit ? r_fwd_data :
                 (r_vld[r_s1_req.addr] ? rd_data : '0);
    assign inc = (&cur) ? cur : cur + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_hit   <= 1'b0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            r_fwd_hit <= we && take && (i_req.addr == r_s1_req.addr);
            if (we) begin
                r_vld[r_s1_req.addr] <= 1'b1;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_req <= i_req;
        end
        r_fwd_data <= inc;
        if (adv) begin
            r_out_done  <= 1'b0;
            r_out_hit   <= 1'b0;
            r_out_idx   <= '0;
            r_out_count <= '0;
            case (r_s1_req.op)
                OP_DONE: begin
                    r_out_done <= 1'b1;
                end
                OP_INC: begin
                    r_out_done  <= 1'b1;
                    r_out_hit   <= 1'b1;
                    r_out_idx   <= r_s1_req.addr;
                    r_out_count <= inc;
                end
                OP_READ: begin
                    r_out_idx   <= r_s1_req.addr;
                    r_out_count <= cur;
                end
                default: begin
                    r_out_done <= 1'b0;
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.word_done   = r_out_done;
    assign o_result.keyword_hit = r_out_hit;
    assign o_result.hit_index   = r_out_idx;
    assign o_result.count_value = r_out_count;
endmodule

FILE: rtl/core/kocnt_checker.sv
`include "keyword_occurrence_counter_defines.svh"

module kocnt_checker import kocnt_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic                 i_word_done,
    input logic                 i_keyword_hit,
    input logic [KEY_IDX_W-1:0] i_hit_index,
    input logic [COUNT_W-1:0]   i_count_value
);
    `KOC_ASSERT_NOW(a_hit_closes_word, i_out_valid && i_keyword_hit, i_word_done && (i_count_value != '0))
    `KOC_ASSERT_NOW(a_miss_is_blank, i_out_valid && i_word_done && !i_keyword_hit, (i_hit_index == '0) && (i_count_value == '0))
    `KOC_ASSERT_NOW(a_reset_empty, $past(!i_rst_n), !i_out_valid)
    `KOC_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_count_value) && $stable(i_hit_index))
endmodule

bind keyword_occurrence_counter kocnt_checker u_kocnt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_word_done   (o_result.word_done),
    .i_keyword_hit (o_result.keyword_hit),
    .i_hit_index   (o_result.hit_index),
    .i_count_value (o_result.count_value)
);
